### src/mpe_pkg.sv
// shared types and constants for the messagepack value encoder
// no dependencies

package mpe_pkg;

    localparam int MAX_BYTES = 9;
    localparam int BUF_W     = 8 * MAX_BYTES;
    localparam int CNT_W     = 4;

    typedef enum logic [4:0] {
        OP_NIL    = 5'd0,
        OP_BOOL   = 5'd1,
        OP_UINT8  = 5'd2,
        OP_UINT16 = 5'd3,
        OP_UINT32 = 5'd4,
        OP_UINT64 = 5'd5,
        OP_INT8   = 5'd6,
        OP_INT16  = 5'd7,
        OP_INT32  = 5'd8,
        OP_INT64  = 5'd9,
        OP_F32    = 5'd10,
        OP_F64    = 5'd11,
        OP_STR    = 5'd12,
        OP_BIN    = 5'd13,
        OP_ARRAY  = 5'd14,
        OP_MAP    = 5'd15,
        OP_EXT    = 5'd16,
        OP_RAW    = 5'd17
    } t_op;

    // header codes
    localparam logic [7:0] MP_NIL      = 8'hc0;
    localparam logic [7:0] MP_FALSE    = 8'hc2;
    localparam logic [7:0] MP_TRUE     = 8'hc3;
    localparam logic [7:0] MP_BIN8     = 8'hc4;
    localparam logic [7:0] MP_BIN16    = 8'hc5;
    localparam logic [7:0] MP_BIN32    = 8'hc6;
    localparam logic [7:0] MP_EXT8     = 8'hc7;
    localparam logic [7:0] MP_EXT16    = 8'hc8;
    localparam logic [7:0] MP_EXT32    = 8'hc9;
    localparam logic [7:0] MP_F32      = 8'hca;
    localparam logic [7:0] MP_F64      = 8'hcb;
    localparam logic [7:0] MP_UINT8    = 8'hcc;
    localparam logic [7:0] MP_UINT16   = 8'hcd;
    localparam logic [7:0] MP_UINT32   = 8'hce;
    localparam logic [7:0] MP_UINT64   = 8'hcf;
    localparam logic [7:0] MP_INT8     = 8'hd0;
    localparam logic [7:0] MP_INT16    = 8'hd1;
    localparam logic [7:0] MP_INT32    = 8'hd2;
    localparam logic [7:0] MP_INT64    = 8'hd3;
    localparam logic [7:0] MP_FIXEXT1  = 8'hd4;
    localparam logic [7:0] MP_FIXEXT2  = 8'hd5;
    localparam logic [7:0] MP_FIXEXT4  = 8'hd6;
    localparam logic [7:0] MP_FIXEXT8  = 8'hd7;
    localparam logic [7:0] MP_FIXEXT16 = 8'hd8;
    localparam logic [7:0] MP_STR8     = 8'hd9;
    localparam logic [7:0] MP_STR16    = 8'hda;
    localparam logic [7:0] MP_STR32    = 8'hdb;
    localparam logic [7:0] MP_ARRAY16  = 8'hdc;
    localparam logic [7:0] MP_ARRAY32  = 8'hdd;
    localparam logic [7:0] MP_MAP16    = 8'hde;
    localparam logic [7:0] MP_MAP32    = 8'hdf;
    localparam logic [7:0] MP_FIXSTR   = 8'ha0;
    localparam logic [7:0] MP_FIXARRAY = 8'h90;
    localparam logic [7:0] MP_FIXMAP   = 8'h80;

    // fix-format limits
    localparam logic [7:0]  POS_FIX_MAX   = 8'd127;
    localparam logic [7:0]  NEG_FIX_MIN   = 8'he0;   // -32 as a byte
    localparam logic [31:0] FIXSTR_MAX    = 32'd31;
    localparam logic [31:0] FIXCOUNT_MAX  = 32'd15;
    localparam logic [31:0] LEN8_MAX      = 32'd255;
    localparam logic [31:0] LEN16_MAX     = 32'd65535;

    // encoded bytes, left aligned, first byte in the top lane
    typedef struct packed {
        logic [BUF_W-1:0] bytes;
        logic [CNT_W-1:0] cnt;
    } t_pack;

endpackage

### src/mpe_pack.sv
// combinational encoder: one tagged item to up to nine left-aligned bytes
// depends on mpe_pkg

module mpe_pack
    import mpe_pkg::*;
(
    input  logic [4:0]  i_op,
    input  logic [63:0] i_value,
    input  logic [31:0] i_length,
    input  logic [7:0]  i_ext_type,
    output t_pack       o_pack
);

    logic [7:0]  b;
    logic [31:0] len;

    assign b   = i_value[7:0];
    assign len = i_length;

    always_comb begin
        o_pack = '0;
        unique case (i_op) inside
            OP_NIL: begin
                o_pack.bytes = {MP_NIL, 64'd0};
                o_pack.cnt   = 4'd1;
            end
            OP_BOOL: begin
                o_pack.bytes = {(i_value[0] ? MP_TRUE : MP_FALSE), 64'd0};
                o_pack.cnt   = 4'd1;
            end
            OP_UINT8: begin
                if (b <= POS_FIX_MAX) begin
                    o_pack.bytes = {b, 64'd0};
                    o_pack.cnt   = 4'd1;
                end else begin
                    o_pack.bytes = {MP_UINT8, b, 56'd0};
                    o_pack.cnt   = 4'd2;
                end
            end
            OP_UINT16: begin
                o_pack.bytes = {MP_UINT16, i_value[15:0], 48'd0};
                o_pack.cnt   = 4'd3;
            end
            OP_UINT32: begin
                o_pack.bytes = {MP_UINT32, i_value[31:0], 32'd0};
                o_pack.cnt   = 4'd5;
            end
            OP_UINT64: begin
                o_pack.bytes = {MP_UINT64, i_value};
                o_pack.cnt   = 4'd9;
            end
            OP_INT8: begin
                if (b >= NEG_FIX_MIN) begin
                    o_pack.bytes = {b, 64'd0};
                    o_pack.cnt   = 4'd1;
                end else begin
                    o_pack.bytes = {MP_INT8, b, 56'd0};
                    o_pack.cnt   = 4'd2;
                end
            end
            OP_INT16: begin
                o_pack.bytes = {MP_INT16, i_value[15:0], 48'd0};
                o_pack.cnt   = 4'd3;
            end
            OP_INT32: begin
                o_pack.bytes = {MP_INT32, i_value[31:0], 32'd0};
                o_pack.cnt   = 4'd5;
            end
            OP_INT64: begin
                o_pack.bytes = {MP_INT64, i_value};
                o_pack.cnt   = 4'd9;
            end
            OP_F32: begin
                o_pack.bytes = {MP_F32, i_value[31:0], 32'd0};
                o_pack.cnt   = 4'd5;
            end
            OP_F64: begin
                o_pack.bytes = {MP_F64, i_value};
                o_pack.cnt   = 4'd9;
            end
            OP_STR: begin
                if (len <= FIXSTR_MAX) begin
                    o_pack.bytes = {(MP_FIXSTR | len[7:0]), 64'd0};
                    o_pack.cnt   = 4'd1;
                end else if (len <= LEN8_MAX) begin
                    o_pack.bytes = {MP_STR8, len[7:0], 56'd0};
                    o_pack.cnt   = 4'd2;
                end else if (len <= LEN16_MAX) begin
                    o_pack.bytes = {MP_STR16, len[15:0], 48'd0};
                    o_pack.cnt   = 4'd3;
                end else begin
                    o_pack.bytes = {MP_STR32, len, 32'd0};
                    o_pack.cnt   = 4'd5;
                end
            end
            OP_BIN: begin
                if (len <= LEN8_MAX) begin
                    o_pack.bytes = {MP_BIN8, len[7:0], 56'd0};
                    o_pack.cnt   = 4'd2;
                end else if (len <= LEN16_MAX) begin
                    o_pack.bytes = {MP_BIN16, len[15:0], 48'd0};
                    o_pack.cnt   = 4'd3;
                end else begin
                    o_pack.bytes = {MP_BIN32, len, 32'd0};
                    o_pack.cnt   = 4'd5;
                end
            end
            OP_ARRAY, OP_MAP: begin
                if (len <= FIXCOUNT_MAX) begin
                    o_pack.bytes = {(((i_op == OP_MAP) ? MP_FIXMAP : MP_FIXARRAY)
                                     | len[7:0]), 64'd0};
                    o_pack.cnt   = 4'd1;
                end else if (len <= LEN16_MAX) begin
                    o_pack.bytes = {((i_op == OP_MAP) ? MP_MAP16 : MP_ARRAY16),
                                    len[15:0], 48'd0};
                    o_pack.cnt   = 4'd3;
                end else begin
                    o_pack.bytes = {((i_op == OP_MAP) ? MP_MAP32 : MP_ARRAY32),
                                    len, 32'd0};
                    o_pack.cnt   = 4'd5;
                end
            end
            OP_EXT: begin
                case (len)
                    32'd1:  o_pack.bytes = {MP_FIXEXT1, i_ext_type, 56'd0};
                    32'd2:  o_pack.bytes = {MP_FIXEXT2, i_ext_type, 56'd0};
                    32'd4:  o_pack.bytes = {MP_FIXEXT4, i_ext_type, 56'd0};
                    32'd8:  o_pack.bytes = {MP_FIXEXT8, i_ext_type, 56'd0};
                    32'd16: o_pack.bytes = {MP_FIXEXT16, i_ext_type, 56'd0};
                    default: begin
                        if (len <= LEN8_MAX)
                            o_pack.bytes = {MP_EXT8, len[7:0], i_ext_type, 48'd0};
                        else if (len <= LEN16_MAX)
                            o_pack.bytes = {MP_EXT16, len[15:0], i_ext_type, 40'd0};
                        else
                            o_pack.bytes = {MP_EXT32, len, i_ext_type, 24'd0};
                    end
                endcase
                case (len) inside
                    32'd1, 32'd2, 32'd4, 32'd8, 32'd16: o_pack.cnt = 4'd2;
                    default: begin
                        if (len <= LEN8_MAX)
                            o_pack.cnt = 4'd3;
                        else if (len <= LEN16_MAX)
                            o_pack.cnt = 4'd4;
                        else
                            o_pack.cnt = 4'd6;
                    end
                endcase
            end
            OP_RAW: begin
                o_pack.bytes = {b, 64'd0};
                o_pack.cnt   = 4'd1;
            end
            // unused codes produce nothing
            default: begin
                o_pack = '0;
            end
        endcase
    end

endmodule

### src/msgpack_value_encoder.sv
// messagepack value encoder top level: byte buffer and output register
// depends on mpe_pkg and mpe_pack
// an accepted request loads the byte buffer, whose bytes then move into the output register
// throughput: the input stalls until the buffer drains its last byte (raw bytes: one per
// cycle while i_stall is low); the byte buffer shifting one byte a cycle into the output
// register, unless i_stall holds it, sets this rate; unused op codes produce no byte
// reset (synchronous, active low) empties the buffer and the output register

module msgpack_value_encoder
    import mpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_op,
    input  logic [63:0] i_value,
    input  logic [31:0] i_length,
    input  logic [7:0]  i_ext_type,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    t_pack            dec;
    logic [BUF_W-1:0] r_buf, n_buf;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;
    logic             adv;
    logic             move;
    logic             accept;

    mpe_pack u_pack (
        .i_op       (i_op),
        .i_value    (i_value),
        .i_length   (i_length),
        .i_ext_type (i_ext_type),
        .o_pack     (dec)
    );

    // output register free to take a byte this cycle
    assign adv     = !r_valid || !i_stall;
    assign move    = adv && (r_cnt != '0);
    assign o_stall = !((r_cnt == '0) || ((r_cnt == CNT_W'(1)) && adv));
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        if (move) begin
            n_byte  = r_buf[BUF_W-1 -: 8];
            n_last  = (r_cnt == CNT_W'(1));
            n_valid = 1'b1;
            n_buf   = {r_buf[BUF_W-9:0], 8'h00};
            n_cnt   = r_cnt - CNT_W'(1);
        end else if (adv) begin
            n_valid = 1'b0;
        end
        // buffer is empty or draining its last byte when a request is taken
        if (accept) begin
            n_buf = dec.bytes;
            n_cnt = dec.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
        r_buf  <= n_buf;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BYTES))
        else $error("byte count beyond buffer depth");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("gap inside an encoded item");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_cnt == $past(dec.cnt)))
        else $error("buffer count does not match encoded length");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && (r_cnt == CNT_W'(1)) && !accept) |=> (r_cnt == '0))
        else $error("buffer not empty after last byte");
`endif

endmodule

### tb/tb_msgpack_value_encoder.sv
`timescale 1ns / 1ps
// self-checking bench for msgpack_value_encoder: directed corners and random bursts of tagged requests
// against a byte-level encoding predictor; depends on mpe_pkg and the encoder rtl

module tb_msgpack_value_encoder;
    import mpe_pkg::*;

    localparam int OP_CODE_MAX  = 31;
    localparam int RANDOM_ITEMS = 200;
    localparam int SETTLE_CYC   = 20;

    typedef struct {
        logic [4:0]  op;
        logic [63:0] value;
        logic [31:0] length;
        logic [7:0]  ext_type;
        bit          drain;     // hold this request until all bytes are out
    } t_enc_req;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_enc_byte;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [4:0]  i_op       = '0;
    logic [63:0] i_value    = '0;
    logic [31:0] i_length   = '0;
    logic [7:0]  i_ext_type = '0;
    logic        i_stall    = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_last;

    t_enc_req    pending_reqs[$];
    t_enc_byte   expected_bytes[$];
    logic [7:0]  enc_buf[$];
    bit          bytes_drained = 1'b1;
    bit          drain_next    = 1'b0;
    int          n_fail        = 0;
    int          n_items       = 0;

    msgpack_value_encoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_length   (i_length),
        .i_ext_type (i_ext_type),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic void add_byte(input logic [7:0] b);
        enc_buf = {enc_buf, b};
    endfunction

    function automatic void put_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            add_byte(v[8*i +: 8]);
        end
    endfunction

    // length header: 8-bit tier only for str, bin and ext
    function automatic void put_len(input logic [31:0] len, input bit with8,
                                    input logic [7:0] c8, input logic [7:0] c16,
                                    input logic [7:0] c32);
        if (with8 && len <= LEN8_MAX) begin
            add_byte(c8);
            put_be(len, 1);
        end else if (len <= LEN16_MAX) begin
            add_byte(c16);
            put_be(len, 2);
        end else begin
            add_byte(c32);
            put_be(len, 4);
        end
    endfunction

    function automatic void encode_request(input t_enc_req r);
        logic [7:0] lo;
        lo = r.value[7:0];
        enc_buf.delete();
        case (r.op)
            OP_NIL:    add_byte(MP_NIL);
            OP_BOOL:   add_byte(r.value[0] ? MP_TRUE : MP_FALSE);
            OP_UINT8: begin
                if (lo > POS_FIX_MAX) add_byte(MP_UINT8);
                add_byte(lo);
            end
            OP_UINT16: begin add_byte(MP_UINT16); put_be(r.value, 2); end
            OP_UINT32: begin add_byte(MP_UINT32); put_be(r.value, 4); end
            OP_UINT64: begin add_byte(MP_UINT64); put_be(r.value, 8); end
            OP_INT8: begin
                if (lo < NEG_FIX_MIN) add_byte(MP_INT8);
                add_byte(lo);
            end
            OP_INT16:  begin add_byte(MP_INT16); put_be(r.value, 2); end
            OP_INT32:  begin add_byte(MP_INT32); put_be(r.value, 4); end
            OP_INT64:  begin add_byte(MP_INT64); put_be(r.value, 8); end
            OP_F32:    begin add_byte(MP_F32); put_be(r.value, 4); end
            OP_F64:    begin add_byte(MP_F64); put_be(r.value, 8); end
            OP_STR: begin
                if (r.length <= FIXSTR_MAX) add_byte(MP_FIXSTR | r.length[7:0]);
                else put_len(r.length, 1'b1, MP_STR8, MP_STR16, MP_STR32);
            end
            OP_BIN:    put_len(r.length, 1'b1, MP_BIN8, MP_BIN16, MP_BIN32);
            OP_ARRAY: begin
                if (r.length <= FIXCOUNT_MAX) add_byte(MP_FIXARRAY | r.length[7:0]);
                else put_len(r.length, 1'b0, MP_ARRAY16, MP_ARRAY16, MP_ARRAY32);
            end
            OP_MAP: begin
                if (r.length <= FIXCOUNT_MAX) add_byte(MP_FIXMAP | r.length[7:0]);
                else put_len(r.length, 1'b0, MP_MAP16, MP_MAP16, MP_MAP32);
            end
            OP_EXT: begin
                case (r.length)
                    32'd1:   add_byte(MP_FIXEXT1);
                    32'd2:   add_byte(MP_FIXEXT2);
                    32'd4:   add_byte(MP_FIXEXT4);
                    32'd8:   add_byte(MP_FIXEXT8);
                    32'd16:  add_byte(MP_FIXEXT16);
                    default: put_len(r.length, 1'b1, MP_EXT8, MP_EXT16, MP_EXT32);
                endcase
                add_byte(r.ext_type);
            end
            OP_RAW:    add_byte(lo);
            default: ;  // unused codes are swallowed
        endcase
        for (int i = 0; i < enc_buf.size(); i++) begin
            expected_bytes.insert(expected_bytes.size(),
                                  '{data: enc_buf[i], last: (i == enc_buf.size() - 1)});
        end
    endfunction

    // ---------------- driver ----------------

    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin : drv
        t_enc_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].drain || (!i_valid && bytes_drained))) begin
                nxt = pending_reqs.pop_front();
                i_op       <= nxt.op;
                i_value    <= nxt.value;
                i_length   <= nxt.length;
                i_ext_type <= nxt.ext_type;
                i_valid    <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver stall pattern ----------------

    logic [15:0] stall_pat   = '0;
    int          stall_phase = 1;

    always @(posedge i_clk) begin
        stall_pat   = {stall_pat[0], stall_pat[15:1]};
        stall_phase = stall_phase - 1;
        if (stall_phase == 0) begin
            stall_phase = $urandom_range(40, 120);
            case ($urandom_range(0, 3))
                0:       stall_pat = '0;
                1:       stall_pat = 16'($urandom);
                2:       stall_pat = 16'($urandom | $urandom);
                default: stall_pat = 16'($urandom & $urandom);
            endcase
        end
        i_stall <= stall_pat[0];
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin : mon
        t_enc_req  seen;
        t_enc_byte want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                seen = '{op: i_op, value: i_value, length: i_length,
                         ext_type: i_ext_type, drain: 1'b0};
                encode_request(seen);
            end
            if (o_valid && !i_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: expected none, actual %02h", o_out_byte);
                    n_fail++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, o_out_byte);
                        n_fail++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, o_last);
                        n_fail++;
                    end
                end
            end
            bytes_drained <= (expected_bytes.size() == 0);
        end
    end

    // ---------------- stimulus ----------------

    function automatic void add_req(input logic [4:0] op, input logic [63:0] v,
                                    input logic [31:0] len, input logic [7:0] et);
        pending_reqs.insert(pending_reqs.size(),
                            '{op: op, value: v, length: len, ext_type: et,
                              drain: drain_next});
        drain_next = 1'b0;
        if (op <= OP_RAW) n_items++;
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       v[7:0] = 8'(POS_FIX_MAX + $urandom_range(0, 1));
            1:       v[7:0] = 8'(NEG_FIX_MIN - $urandom_range(0, 1));
            2:       v[7:0] = $urandom_range(0, 1) ? 8'h00 : 8'hff;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_len();
        logic [31:0] edge_len;
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 40);
            1: begin
                case ($urandom_range(0, 3))
                    0:       edge_len = FIXCOUNT_MAX;
                    1:       edge_len = FIXSTR_MAX;
                    2:       edge_len = LEN8_MAX;
                    default: edge_len = LEN16_MAX;
                endcase
                return edge_len + $urandom_range(0, 1);
            end
            2: return $urandom_range(0, 70000);
            3: return $urandom;
            default: return 32'd1 << $urandom_range(0, 4);  // fixext sizes
        endcase
    endfunction

    initial begin
        int          cnt;
        logic [4:0]  op;
        logic [31:0] len;

        // directed corners: fix/non-fix boundaries, oversize values, zero lengths
        add_req(OP_NIL,    '0, '0, '0);
        add_req(OP_BOOL,   64'hffff_ffff_ffff_fffe, '1, '1);
        add_req(OP_BOOL,   64'h1, '0, '0);
        add_req(OP_UINT8,  64'd127, '0, '0);
        add_req(OP_UINT8,  64'hffff_ffff_ffff_ff80, '0, '0);
        add_req(OP_UINT16, '1, '0, '0);
        add_req(OP_UINT32, 64'h0123_4567_89ab_cdef, '0, '0);
        add_req(OP_UINT64, '0, '0, '0);
        add_req(OP_INT8,   64'h0000_0000_0000_00e0, '0, '0);
        add_req(OP_INT8,   64'hffff_ffff_ffff_ffdf, '0, '0);
        add_req(OP_INT16,  64'h8000, '0, '0);
        add_req(OP_INT32,  '1, '0, '0);
        add_req(OP_INT64,  64'h8000_0000_0000_0000, '0, '0);
        add_req(OP_F32,    64'h3f80_0000, '0, '0);
        add_req(OP_F64,    64'h4009_21fb_5444_2d18, '0, '0);
        add_req(OP_STR,    '0, 32'd31, '0);
        add_req(OP_STR,    '0, 32'd32, '0);
        add_req(OP_STR,    '0, 32'd65536, '0);
        add_req(OP_BIN,    '0, 32'd0, '0);
        add_req(OP_BIN,    '0, 32'd256, '0);
        add_req(OP_ARRAY,  '0, 32'd16, '0);
        add_req(OP_MAP,    '1, 32'hffff_ffff, '1);
        add_req(OP_EXT,    '0, 32'd16, 8'hff);
        add_req(OP_EXT,    '0, 32'd0, 8'h00);
        add_req(OP_RAW,    '1, '1, '1);
        add_req(5'(OP_CODE_MAX), '1, '1, '1);

        n_items    = 0;
        drain_next = 1'b1;
        while (n_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 50) == 0) drain_next = 1'b1;
            case ($urandom_range(0, 9)) inside
                0, 1, 2: begin  // str or bin header followed by its payload
                    len = $urandom_range(0, 20);
                    op  = $urandom_range(0, 1) ? OP_STR : OP_BIN;
                    add_req(op, {$urandom, $urandom}, len, 8'($urandom));
                    for (int i = 0; i < len; i++)
                        add_req(OP_RAW, {$urandom, $urandom}, $urandom, 8'($urandom));
                end
                3: begin
                    len = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 4))
                                               : $urandom_range(0, 20);
                    add_req(OP_EXT, {$urandom, $urandom}, len, 8'($urandom));
                    for (int i = 0; i < len; i++)
                        add_req(OP_RAW, {$urandom, $urandom}, $urandom, 8'($urandom));
                end
                4, 5: begin  // container of scalars
                    cnt = $urandom_range(0, 6);
                    op  = $urandom_range(0, 1) ? OP_ARRAY : OP_MAP;
                    add_req(op, {$urandom, $urandom}, cnt, 8'($urandom));
                    if (op == OP_MAP) cnt = 2 * cnt;
                    for (int i = 0; i < cnt; i++)
                        add_req(5'($urandom_range(OP_NIL, OP_F64)), rand_value(), $urandom,
                                8'($urandom));
                end
                6, 7: add_req(5'($urandom_range(OP_NIL, OP_F64)), rand_value(), $urandom,
                              8'($urandom));
                8:    add_req(5'($urandom_range(OP_STR, OP_EXT)), {$urandom, $urandom},
                              rand_len(), 8'($urandom));
                default: begin  // noise: unused codes or a stray raw byte
                    if ($urandom_range(0, 1))
                        add_req(5'($urandom_range(OP_RAW + 1, OP_CODE_MAX)),
                                {$urandom, $urandom}, $urandom, 8'($urandom));
                    else
                        add_req(OP_RAW, {$urandom, $urandom}, $urandom, 8'($urandom));
                end
            endcase
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || !bytes_drained);
        repeat (SETTLE_CYC) @(negedge i_clk);

        if (n_fail == 0 && expected_bytes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
